@@ rtl/adbd_pkg.sv @@
// ---------------------------------------------------------------------------
// ADPCM block decoder package
// Shared types, constants and filter coefficient tables.
// ---------------------------------------------------------------------------
package adbd_pkg;

    localparam int unsigned SHIFT_W   = 4;
    localparam int unsigned FILTER_W  = 3;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned COEF_W    = 8;

    localparam logic [POS_W-1:0]    POS_HEADER  = 4'd0;
    localparam logic [POS_W-1:0]    POS_FLAGS   = 4'd1;
    localparam logic [POS_W-1:0]    POS_LAST    = 4'd15;
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX   = 4'd12;
    localparam logic [SHIFT_W-1:0]  SHIFT_SUBST = 4'd9;
    localparam logic [FILTER_W-1:0] FILTER_MAX  = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        logic                valid;
        logic [3:0]          nibble;
        logic [SHIFT_W-1:0]  shift;
        logic [FILTER_W-1:0] filter;
        logic                last;
    } item_t;

    function automatic coef_t coef_pos(input logic [FILTER_W-1:0] f);
        coef_t c;
        case (f)
            3'd0:    c = 8'sd0;
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic coef_t coef_neg(input logic [FILTER_W-1:0] f);
        coef_t c;
        case (f)
            3'd0:    c = 8'sd0;
            3'd1:    c = 8'sd0;
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/adbd_sample_calc.sv @@
// ---------------------------------------------------------------------------
// ADPCM sample calculation
// Scales one nibble, adds the prediction from the sample history and
// saturates the result to 16 bits.
// ---------------------------------------------------------------------------
module adbd_sample_calc (
    input  logic [3:0]                      nibble,
    input  logic [adbd_pkg::SHIFT_W-1:0]    shift,
    input  logic [adbd_pkg::FILTER_W-1:0]   filter,
    input  adbd_pkg::sample_t               newest,
    input  adbd_pkg::sample_t               older,
    output adbd_pkg::sample_t               sample
);
    import adbd_pkg::*;

    logic signed [15:0] scaled;
    logic signed [15:0] shifted;
    logic signed [23:0] newest_ext;
    logic signed [23:0] older_ext;
    logic signed [23:0] cpos_ext;
    logic signed [23:0] cneg_ext;
    logic signed [23:0] prod_pos;
    logic signed [23:0] prod_neg;
    logic signed [24:0] acc;
    logic signed [24:0] biased;
    logic signed [18:0] pred;
    logic signed [19:0] total;

    assign scaled     = $signed({nibble, 12'h000});
    assign shifted    = scaled >>> shift;
    assign newest_ext = 24'(newest);
    assign older_ext  = 24'(older);
    assign cpos_ext   = 24'(coef_pos(filter));
    assign cneg_ext   = 24'(coef_neg(filter));
    assign prod_pos   = newest_ext * cpos_ext;
    assign prod_neg   = older_ext * cneg_ext;
    assign acc        = 25'(prod_pos) + 25'(prod_neg) + 25'sd32;
    // Division by 64 rounds toward zero, so negative sums are biased first.
    assign biased     = acc[24] ? (acc + 25'sd63) : acc;
    assign pred       = $signed(biased[24:6]);
    assign total      = 20'(shifted) + 20'(pred);

    always_comb
    begin
        if (total > 20'sd32767)
        begin
            sample = 16'sh7fff;
        end
        else if (total < -20'sd32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = total[15:0];
        end
    end

endmodule

@@ rtl/adbd_front.sv @@
// ---------------------------------------------------------------------------
// ADPCM block front end
// Tracks the byte position, latches the header and holds one data byte
// while its two nibbles are decoded.
// ---------------------------------------------------------------------------
module adbd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              take,
    output adbd_pkg::item_t   item
);
    import adbd_pkg::*;

    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [SHIFT_W-1:0]  shift_reg,   shift_next;
    logic [FILTER_W-1:0] filter_reg,  filter_next;
    logic                busy_reg,    busy_next;
    logic                half_reg,    half_next;
    logic [7:0]          byte_reg,    byte_next;
    logic [SHIFT_W-1:0]  ishift_reg,  ishift_next;
    logic [FILTER_W-1:0] ifilter_reg, ifilter_next;
    logic                ilast_reg,   ilast_next;

    logic accept;
    logic done;
    logic [SHIFT_W-1:0]  hdr_shift;
    logic [FILTER_W-1:0] hdr_filter;

    assign done       = busy_reg && half_reg && take;
    assign in_stall   = busy_reg && !done;
    assign accept     = in_valid && !in_stall;
    assign hdr_shift  = (data_byte[3:0] > SHIFT_MAX) ? SHIFT_SUBST : data_byte[3:0];
    assign hdr_filter = (data_byte[6:4] > FILTER_MAX) ? FILTER_MAX : data_byte[6:4];

    always_comb
    begin
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        filter_next  = filter_reg;
        busy_next    = busy_reg;
        half_next    = half_reg;
        byte_next    = byte_reg;
        ishift_next  = ishift_reg;
        ifilter_next = ifilter_reg;
        ilast_next   = ilast_reg;

        if (busy_reg && take)
        begin
            if (half_reg)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
            end
        end

        if (accept)
        begin
            pos_next = pos_reg + 4'd1;
            if (pos_reg == POS_HEADER)
            begin
                shift_next  = hdr_shift;
                filter_next = hdr_filter;
            end
            else if (pos_reg != POS_FLAGS)
            begin
                busy_next    = 1'b1;
                half_next    = 1'b0;
                byte_next    = data_byte;
                ishift_next  = shift_reg;
                ifilter_next = filter_reg;
                ilast_next   = (pos_reg == POS_LAST);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            shift_reg  <= '0;
            filter_reg <= '0;
            busy_reg   <= 1'b0;
            half_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            filter_reg <= filter_next;
            busy_reg   <= busy_next;
            half_reg   <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        ishift_reg  <= ishift_next;
        ifilter_reg <= ifilter_next;
        ilast_reg   <= ilast_next;
    end

    assign item.valid  = busy_reg;
    assign item.nibble = half_reg ? byte_reg[7:4] : byte_reg[3:0];
    assign item.shift  = ishift_reg;
    assign item.filter = ifilter_reg;
    assign item.last   = ilast_reg && half_reg;

endmodule

@@ rtl/adpcm_block_decoder.sv @@
// ---------------------------------------------------------------------------
// ADPCM block decoder
// Each data byte is held in the front end and its two samples are computed in
// turn by the single sample unit through the sample history loop, each into the
// output register; a new byte is accepted as its second sample is taken.
// Reset clears the byte position, header fields and sample history to zero.
// ---------------------------------------------------------------------------
module adpcm_block_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [15:0]        sample,
    output logic                      last_of_block
);
    import adbd_pkg::*;

    item_t   item;
    sample_t calc_sample;
    logic    out_adv;
    logic    take;

    sample_t newest_reg, newest_next;
    sample_t older_reg,  older_next;
    logic    out_valid_reg, out_valid_next;
    sample_t out_sample_reg, out_sample_next;
    logic    out_last_reg,   out_last_next;

    adbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .take      (take),
        .item      (item)
    );

    adbd_sample_calc u_calc (
        .nibble (item.nibble),
        .shift  (item.shift),
        .filter (item.filter),
        .newest (newest_reg),
        .older  (older_reg),
        .sample (calc_sample)
    );

    assign out_adv = !out_valid_reg || !out_stall;
    assign take    = item.valid && out_adv;

    always_comb
    begin
        newest_next     = newest_reg;
        older_next      = older_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        if (out_adv)
        begin
            out_valid_next = take;
        end
        if (take)
        begin
            newest_next     = calc_sample;
            older_next      = newest_reg;
            out_sample_next = calc_sample;
            out_last_next   = item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg    <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            newest_reg    <= newest_next;
            older_reg     <= older_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign sample        = out_sample_reg;
    assign last_of_block = out_last_reg;

endmodule
